/* src/packet_body_checksum_check_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the packet body checksum check
// Shorthand for clocked implication checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef PACKET_BODY_CHECKSUM_CHECK_MACROS_SVH
`define PACKET_BODY_CHECKSUM_CHECK_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PBCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbcc assertion failed");

// consequent must hold in the cycle after the antecedent
`define PBCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbcc assertion failed");

`endif

/* src/pbcc_pkg.sv */
// ---------------------------------------------------------------------------
// Packet body checksum check package
// Payload types, codes and header size constants shared by the block.
// ---------------------------------------------------------------------------
package pbcc_pkg;

   localparam int unsigned LEN_W = 20;

   localparam logic [LEN_W-1:0] STD_HEADER_BYTES = 20'd24;
   localparam logic [LEN_W-1:0] SEC_HEADER_BYTES = 20'd12;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_SUM8 = 2'd1,
      MODE_SUM16 = 2'd2,
      MODE_SUM32 = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_MATCH = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_NOT_PRESENT = 2'd2,
      STATUS_LENGTH_ERROR = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic first_of_packet;
      logic [LEN_W-1:0] packet_bytes;
      logic has_secondary;
      logic [1:0] checksum_mode;
   } req_payload_type;

   typedef struct packed {
      status_type check_status;
      logic [31:0] computed_sum;
      logic [31:0] recorded_sum;
   } rsp_payload_type;

   typedef struct packed {
      logic valid;
      req_payload_type item;
   } stage_type;

   function automatic logic [2:0] unit_bytes(input logic [1:0] mode);
      logic [2:0] u;
      unique case (mode)
         MODE_SUM8: u = 3'd1;
         MODE_SUM16: u = 3'd2;
         default: u = 3'd4;
      endcase
      return u;
   endfunction

   function automatic logic [31:0] unit_mask(input logic [1:0] mode);
      logic [31:0] m;
      unique case (mode)
         MODE_SUM8: m = 32'h0000_00FF;
         MODE_SUM16: m = 32'h0000_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

/* src/pbcc_if.sv */
// ---------------------------------------------------------------------------
// Packet body checksum check channels
// Valid/ready channels for body byte requests and check responses.
// ---------------------------------------------------------------------------
interface pbcc_req_if import pbcc_pkg::*; ();
   logic valid;
   logic ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pbcc_rsp_if import pbcc_pkg::*; ();
   logic valid;
   logic ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* src/pbcc_in_stage.sv */
// ---------------------------------------------------------------------------
// Packet body checksum check input stage
// Registers one request transaction and hands it to the checksum core.
// ---------------------------------------------------------------------------
module pbcc_in_stage import pbcc_pkg::*; (
   input logic clock,
   input logic reset,
   pbcc_req_if.sink req_ch,
   input logic advance,
   output stage_type stage
);

   logic valid_ff;
   logic valid_in;
   req_payload_type item_ff;

   assign req_ch.ready = !valid_ff || advance;

   always_comb begin
      if (req_ch.valid && req_ch.ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold payload until a new transaction is taken
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff <= req_ch.payload;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item = item_ff;

endmodule

/* src/pbcc_core.sv */
// ---------------------------------------------------------------------------
// Packet body checksum check core
// Tracks the packet, sums body units, captures the trailer, emits status.
// ---------------------------------------------------------------------------
module pbcc_core import pbcc_pkg::*; (
   input logic clock,
   input logic reset,
   input stage_type stage,
   output logic advance,
   pbcc_rsp_if.source rsp_ch
);

   logic active_ff, active_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0] mode_ff, mode_in;
   logic [31:0] sum_ff, sum_in;
   logic [23:0] asm_ff, asm_in;
   logic [31:0] trl_ff, trl_in;

   logic rsp_valid_ff;
   rsp_payload_type rsp_ff;
   logic emit;
   rsp_payload_type rsp_in;

   logic first;
   logic [1:0] eff_mode;
   logic [2:0] ubytes;
   logic [1:0] umask;
   logic [LEN_W-1:0] hdr;
   logic size_short;
   logic [LEN_W-1:0] body_new;
   logic len_short;
   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] sumlen;
   logic [LEN_W-1:0] whole;
   logic [LEN_W-1:0] p;
   logic [31:0] sum_cur;
   logic [23:0] asm_cur;
   logic [31:0] trl_cur;
   logic [1:0] k;
   logic [1:0] kt;
   logic [31:0] part;
   logic [31:0] shifted;
   logic [31:0] shifted_trl;
   logic [31:0] step_sum;
   logic [23:0] step_asm;
   logic [31:0] step_trl;
   logic [LEN_W:0] p_inc;
   logic done;

   assign advance = stage.valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      first = stage.item.first_of_packet;
      eff_mode = first ? stage.item.checksum_mode : mode_ff;
      ubytes = unit_bytes(eff_mode);
      umask = 2'(ubytes - 3'd1);
      hdr = stage.item.has_secondary ? (STD_HEADER_BYTES + SEC_HEADER_BYTES)
                                     : STD_HEADER_BYTES;
      size_short = stage.item.packet_bytes < hdr;
      body_new = stage.item.packet_bytes - hdr;
      len_short = body_new < {{(LEN_W-3){1'b0}}, ubytes};
      eff_len = first ? body_new : len_ff;
      sumlen = eff_len - {{(LEN_W-3){1'b0}}, ubytes};
      whole = sumlen & ~{{(LEN_W-2){1'b0}}, umask};
      p = first ? '0 : pos_ff;
      sum_cur = first ? '0 : sum_ff;
      asm_cur = first ? '0 : asm_ff;
      trl_cur = first ? '0 : trl_ff;

      k = p[1:0] & umask;
      kt = p[1:0] - sumlen[1:0];
      shifted = {24'b0, stage.item.body_byte} << {k, 3'b000};
      shifted_trl = {24'b0, stage.item.body_byte} << {kt, 3'b000};
      part = {8'b0, asm_cur} | shifted;

      step_sum = sum_cur;
      step_asm = asm_cur;
      step_trl = trl_cur;
      if (p < whole) begin
         if (k == umask) begin
            step_sum = (sum_cur + part) & unit_mask(eff_mode);
            step_asm = '0;
         end else begin
            step_asm = part[23:0];
         end
      end else if (p >= sumlen) begin
         step_trl = trl_cur | shifted_trl;
      end

      p_inc = {1'b0, p} + {{LEN_W{1'b0}}, 1'b1};
      done = p_inc >= {1'b0, eff_len};
   end

   always_comb begin
      active_in = active_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      mode_in = mode_ff;
      sum_in = sum_ff;
      asm_in = asm_ff;
      trl_in = trl_ff;
      emit = 1'b0;
      rsp_in.check_status = STATUS_MATCH;
      rsp_in.computed_sum = step_sum;
      rsp_in.recorded_sum = step_trl;
      if (advance && (first || active_ff)) begin
         mode_in = eff_mode;
         if (first && (stage.item.checksum_mode == MODE_NONE)) begin
            active_in = 1'b0;
            pos_in = '0;
            len_in = '0;
            sum_in = '0;
            asm_in = '0;
            trl_in = '0;
            emit = 1'b1;
            rsp_in.check_status = STATUS_NOT_PRESENT;
            rsp_in.computed_sum = '0;
            rsp_in.recorded_sum = '0;
         end else if (first && (size_short || len_short)) begin
            active_in = 1'b0;
            pos_in = '0;
            len_in = '0;
            sum_in = '0;
            asm_in = '0;
            trl_in = '0;
            emit = 1'b1;
            rsp_in.check_status = STATUS_LENGTH_ERROR;
            rsp_in.computed_sum = '0;
            rsp_in.recorded_sum = '0;
         end else begin
            len_in = eff_len;
            pos_in = p_inc[LEN_W-1:0];
            sum_in = step_sum;
            asm_in = step_asm;
            trl_in = step_trl;
            active_in = !done;
            emit = done;
            rsp_in.check_status = (step_sum == step_trl) ? STATUS_MATCH : STATUS_MISMATCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff <= '0;
         len_ff <= '0;
         mode_ff <= '0;
         sum_ff <= '0;
         asm_ff <= '0;
         trl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         mode_ff <= mode_in;
         sum_ff <= sum_in;
         asm_ff <= asm_in;
         trl_ff <= trl_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

endmodule

/* src/packet_body_checksum_check.sv */
// ---------------------------------------------------------------------------
// Packet body checksum check
// Streams a packet body byte by byte and reports its data checksum status.
// ---------------------------------------------------------------------------
// Accepts one body byte per clock unless the status output stalls, with no
// gaps between packets. The first byte of a packet also carries the packet
// size, secondary header flag and checksum mode. A status transaction for
// the byte that completes it goes through the input register, then the
// result register; the rate is set by the update of the running sum and
// byte position in the checksum core. Mode none and short packets report
// on the first byte. A new first byte drops an open packet without status.
module packet_body_checksum_check import pbcc_pkg::*; (
   input logic clock,
   input logic reset,
   pbcc_req_if.sink req_ch,
   pbcc_rsp_if.source rsp_ch
);

   stage_type stage;
   logic advance;

   pbcc_in_stage u_in_stage (
      .clock (clock),
      .reset (reset),
      .req_ch (req_ch),
      .advance (advance),
      .stage (stage)
   );

   pbcc_core u_core (
      .clock (clock),
      .reset (reset),
      .stage (stage),
      .advance (advance),
      .rsp_ch (rsp_ch)
   );

endmodule

/* src/pbcc_checker.sv */
// ---------------------------------------------------------------------------
// Packet body checksum check port checker
// Checks response handshake and status consistency at the top level ports.
// ---------------------------------------------------------------------------
`include "packet_body_checksum_check_macros.svh"

module pbcc_checker import pbcc_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_payload_type rsp_payload
);

   `PBCC_ASSERT_NEXT(rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PBCC_ASSERT_NEXT(rsp_payload_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `PBCC_ASSERT_SAME(status_matches_sums, clock, reset,
      rsp_valid && (rsp_payload.check_status == STATUS_MATCH || rsp_payload.check_status == STATUS_MISMATCH),
      (rsp_payload.check_status == STATUS_MATCH) == (rsp_payload.computed_sum == rsp_payload.recorded_sum))
   `PBCC_ASSERT_SAME(no_check_zero_sums, clock, reset,
      rsp_valid && (rsp_payload.check_status == STATUS_NOT_PRESENT || rsp_payload.check_status == STATUS_LENGTH_ERROR),
      rsp_payload.computed_sum == 32'd0 && rsp_payload.recorded_sum == 32'd0)

endmodule

bind packet_body_checksum_check pbcc_checker u_pbcc_checker (
   .clock (clock),
   .reset (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

/* tb/packet_body_checksum_check_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Packet body checksum check testbench
// Streams telemetry packet bodies into the block, byte by byte. A short
// table of edge cases comes first: no checksum, short packets, one-byte
// bodies, wrap at the unit width, skipped leftover bytes, restart and idle
// bytes. Random packets follow, with good and bad trailers. Every status
// transaction is compared field by field against the table's expected
// values or an in-bench model of the block. The sender works in bursts
// and the receiver stalls, with long hold-offs that back up the input.
// ---------------------------------------------------------------------------
module packet_body_checksum_check_tb;
   import pbcc_pkg::*;

   typedef struct {
      logic [7:0] body_byte;
      logic first;
      logic [19:0] size;
      logic sec;
      mode_type mode;
      bit typed;
      status_type status;
      logic [31:0] comp;
      logic [31:0] rec;
   } stim_row_type;

   typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_pattern_type;

   localparam int DIRECTED_ROWS = 27;
   localparam int TARGET_BYTES = 1000;

   stim_row_type directed_table [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, 20'd0, 1'b0, MODE_NONE, 1'b1, STATUS_NOT_PRESENT, 32'h0, 32'h0},
      '{8'hFF, 1'b1, 20'd524288, 1'b1, MODE_NONE, 1'b1, STATUS_NOT_PRESENT, 32'h0, 32'h0},
      '{8'h5A, 1'b1, 20'd0, 1'b0, MODE_SUM8, 1'b1, STATUS_LENGTH_ERROR, 32'h0, 32'h0},
      '{8'hA5, 1'b1, 20'd27, 1'b0, MODE_SUM32, 1'b1, STATUS_LENGTH_ERROR, 32'h0, 32'h0},
      '{8'h3C, 1'b1, 20'd37, 1'b1, MODE_SUM16, 1'b1, STATUS_LENGTH_ERROR, 32'h0, 32'h0},
      '{8'h00, 1'b1, 20'd25, 1'b0, MODE_SUM8, 1'b1, STATUS_MATCH, 32'h0, 32'h0},
      '{8'hFF, 1'b1, 20'd25, 1'b0, MODE_SUM8, 1'b1, STATUS_MISMATCH, 32'h0, 32'hFF},
      '{8'hFF, 1'b1, 20'd41, 1'b1, MODE_SUM16, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'hFF, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'hAA, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'hFF, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'hFF, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b1, STATUS_MATCH, 32'hFFFF, 32'hFFFF},
      '{8'h01, 1'b1, 20'd32, 1'b0, MODE_SUM32, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h00, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h00, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h80, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h01, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h00, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h00, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h80, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b1, STATUS_MATCH, 32'h80000001,
        32'h80000001},
      '{8'h11, 1'b1, 20'd524288, 1'b0, MODE_SUM8, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h22, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h33, 1'b1, 20'd100, 1'b1, MODE_NONE, 1'b1, STATUS_NOT_PRESENT, 32'h0, 32'h0},
      '{8'h44, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'hFF, 1'b1, 20'd27, 1'b0, MODE_SUM8, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h02, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b0, STATUS_MATCH, 32'h0, 32'h0},
      '{8'h01, 1'b0, 20'd0, 1'b0, MODE_NONE, 1'b1, STATUS_MATCH, 32'h1, 32'h1}
   };

   logic clock;
   logic reset;

   pbcc_req_if req_ch ();
   pbcc_rsp_if rsp_ch ();

   packet_body_checksum_check dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // in-bench model of the packet state
   logic pk_open;
   logic [19:0] pk_pos;
   logic [19:0] pk_len;
   logic [1:0] pk_mode;
   logic [31:0] pk_sum;
   logic [23:0] pk_part;
   logic [31:0] pk_trailer;

   rsp_payload_type pending_status_q [$];

   int error_count;
   int printed_count;
   int byte_count;
   int packet_count;
   int status_seen [4];
   int burst_left;
   bit sender_steady;
   bit hold_off_request;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #16_000_000;
      $display("timeout: %0d status transactions still pending", pending_status_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (printed_count < 40) begin
         printed_count++;
         $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
      end
   endtask

   function automatic req_payload_type make_item(input logic [7:0] b, input logic first,
                                                 input logic [19:0] size, input logic sec,
                                                 input logic [1:0] mode);
      req_payload_type it;
      it.body_byte = b;
      it.first_of_packet = first;
      it.packet_bytes = size;
      it.has_secondary = sec;
      it.checksum_mode = mode;
      return it;
   endfunction

   task automatic predict_status(input req_payload_type it, output bit produced,
                                 output rsp_payload_type rsp);
      logic [31:0] unit, hdr, size, sumlen, whole, p, k, part, mask;
      produced = 1'b0;
      rsp = '0;
      if (it.first_of_packet) begin
         size = 32'(it.packet_bytes);
         hdr = 32'(STD_HEADER_BYTES) + (it.has_secondary ? 32'(SEC_HEADER_BYTES) : 32'd0);
         pk_open = 1'b0;
         pk_pos = '0;
         pk_sum = '0;
         pk_part = '0;
         pk_trailer = '0;
         pk_mode = it.checksum_mode;
         pk_len = '0;
         if (it.checksum_mode == MODE_NONE) begin
            produced = 1'b1;
            rsp.check_status = STATUS_NOT_PRESENT;
            return;
         end
         unit = 32'd1 << (it.checksum_mode - 2'd1);
         if (size < hdr || size - hdr < unit) begin
            produced = 1'b1;
            rsp.check_status = STATUS_LENGTH_ERROR;
            return;
         end
         pk_len = 20'(size - hdr);
         pk_open = 1'b1;
      end else if (!pk_open) begin
         return;
      end
      case (pk_mode)
         MODE_SUM8: begin
            unit = 32'd1;
            mask = 32'h0000_00FF;
         end
         MODE_SUM16: begin
            unit = 32'd2;
            mask = 32'h0000_FFFF;
         end
         default: begin
            unit = 32'd4;
            mask = 32'hFFFF_FFFF;
         end
      endcase
      sumlen = 32'(pk_len) - unit;
      whole = sumlen & ~(unit - 32'd1);
      p = 32'(pk_pos);
      if (p < whole) begin
         k = p & (unit - 32'd1);
         part = {8'h00, pk_part} | (32'(it.body_byte) << (8 * k));
         if (k == unit - 32'd1) begin
            pk_sum = (pk_sum + part) & mask;
            pk_part = '0;
         end else begin
            pk_part = part[23:0];
         end
      end else if (p >= sumlen) begin
         k = (p - sumlen) & 32'd3;
         pk_trailer = pk_trailer | (32'(it.body_byte) << (8 * k));
      end
      p = p + 32'd1;
      pk_pos = p[19:0];
      if (p >= 32'(pk_len)) begin
         pk_open = 1'b0;
         produced = 1'b1;
         rsp.check_status = (pk_sum == pk_trailer) ? STATUS_MATCH : STATUS_MISMATCH;
         rsp.computed_sum = pk_sum;
         rsp.recorded_sum = pk_trailer;
      end
   endtask

   // entered just after a falling edge, before anything is driven in that step
   task automatic send_byte(input req_payload_type item, input bit typed,
                            input rsp_payload_type typed_rsp);
      int gap;
      bit produced;
      rsp_payload_type rsp;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = sender_steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (item.first_of_packet || pk_open)
         byte_count++;
      if (item.first_of_packet)
         packet_count++;
      predict_status(item, produced, rsp);
      if (typed)
         pending_status_q.push_back(typed_rsp);
      else if (produced)
         pending_status_q.push_back(rsp);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_status_q.size() != 0)
         @(posedge clock);
      @(negedge clock);
      burst_left = 0;
   endtask

   task automatic send_packet(input logic [1:0] mode, input logic sec, input int size,
                              input bit good_sum, input int stop_after);
      logic [7:0] body [];
      int hdr, unit, body_len, sending, whole;
      logic [31:0] acc, mask;
      req_payload_type it;
      hdr = int'(STD_HEADER_BYTES) + (sec ? int'(SEC_HEADER_BYTES) : 0);
      case (mode)
         MODE_SUM8: begin
            unit = 1;
            mask = 32'h0000_00FF;
         end
         MODE_SUM16: begin
            unit = 2;
            mask = 32'h0000_FFFF;
         end
         default: begin
            unit = 4;
            mask = 32'hFFFF_FFFF;
         end
      endcase
      body_len = (size >= hdr) ? size - hdr : 0;
      if (mode == MODE_NONE || body_len < unit)
         sending = 1;
      else
         sending = body_len;
      if (stop_after > 0 && stop_after < sending)
         sending = stop_after;
      body = new[sending];
      foreach (body[i])
         body[i] = 8'($urandom_range(0, 255));
      if (good_sum && mode != MODE_NONE && body_len >= unit && sending == body_len) begin
         whole = (body_len - unit) & ~(unit - 1);
         acc = '0;
         for (int i = 0; i < whole; i++)
            acc = acc + (32'(body[i]) << (8 * (i % unit)));
         acc = acc & mask;
         for (int j = 0; j < unit; j++)
            body[body_len - unit + j] = acc[8*j +: 8];
      end
      for (int i = 0; i < sending; i++) begin
         if (i == 0)
            it = make_item(body[i], 1'b1, 20'(size), sec, mode);
         else
            it = make_item(body[i], 1'b0, 20'($urandom_range(0, 524288)),
                           1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
         send_byte(it, 1'b0, '0);
      end
   endtask

   // hold the receiver off while a run of no-checksum packets backs up the block
   task automatic apply_backpressure();
      hold_off_request = 1'b1;
      sender_steady = 1'b1;
      repeat (32)
         send_byte(make_item(8'($urandom_range(0, 255)), 1'b1,
                             20'($urandom_range(0, 524288)),
                             1'($urandom_range(0, 1)), MODE_NONE), 1'b0, '0);
      drain_results();
   endtask

   task automatic check_response(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_status_q.size() == 0) begin
         report_mismatch("status transaction with nothing pending", 32'(got.check_status),
                         32'h0);
         return;
      end
      want = pending_status_q.pop_front();
      if (got.check_status !== want.check_status)
         report_mismatch("check_status", 32'(got.check_status), 32'(want.check_status));
      if (got.computed_sum !== want.computed_sum)
         report_mismatch("computed_sum", got.computed_sum, want.computed_sum);
      if (got.recorded_sum !== want.recorded_sum)
         report_mismatch("recorded_sum", got.recorded_sum, want.recorded_sum);
      if (!$isunknown(got.check_status))
         status_seen[got.check_status]++;
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         check_response(rsp_ch.payload);
   end

   // receiver: rotate among stall patterns, or hold off on request
   initial begin
      sink_pattern_type pattern;
      int segment_left, hold_left, period, phase;
      pattern = SINK_OPEN;
      segment_left = 0;
      hold_left = 0;
      period = 2;
      phase = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (segment_left == 0) begin
               pattern = sink_pattern_type'($urandom_range(0, 2));
               segment_left = $urandom_range(32, 256);
               period = $urandom_range(2, 5);
            end
            segment_left--;
            phase++;
            case (pattern)
               SINK_OPEN: rsp_ch.ready <= 1'b1;
               SINK_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ((phase % period) == 0);
            endcase
         end
      end
   end

   initial begin
      int r, hdr, unit, size;
      logic sec;
      mode_type mode;
      rsp_payload_type typed_rsp;
      bit mid_pressure_done;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      pk_open = 1'b0;
      pk_pos = '0;
      pk_len = '0;
      pk_mode = '0;
      pk_sum = '0;
      pk_part = '0;
      pk_trailer = '0;
      error_count = 0;
      printed_count = 0;
      byte_count = 0;
      packet_count = 0;
      foreach (status_seen[i])
         status_seen[i] = 0;
      burst_left = 0;
      sender_steady = 1'b0;
      hold_off_request = 1'b0;
      mid_pressure_done = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         typed_rsp.check_status = directed_table[i].status;
         typed_rsp.computed_sum = directed_table[i].comp;
         typed_rsp.recorded_sum = directed_table[i].rec;
         send_byte(make_item(directed_table[i].body_byte, directed_table[i].first,
                             directed_table[i].size, directed_table[i].sec,
                             directed_table[i].mode),
                   directed_table[i].typed, typed_rsp);
      end
      drain_results();
      apply_backpressure();

      while (byte_count < TARGET_BYTES) begin
         sender_steady = ($urandom_range(0, 7) == 0);
         sec = 1'($urandom_range(0, 1));
         hdr = int'(STD_HEADER_BYTES) + (sec ? int'(SEC_HEADER_BYTES) : 0);
         mode = mode_type'($urandom_range(1, 3));
         unit = 1 << (int'(mode) - 1);
         r = $urandom_range(0, 99);
         if (r < 60) begin
            send_packet(mode, sec, hdr + $urandom_range(unit, 40), $urandom_range(0, 9) < 6, 0);
         end else if (r < 68) begin
            send_packet(MODE_NONE, sec, $urandom_range(0, 524288), 1'b0, 0);
         end else if (r < 76) begin
            if ($urandom_range(0, 1))
               size = $urandom_range(0, hdr - 1);
            else
               size = hdr + $urandom_range(0, unit - 1);
            send_packet(mode, sec, size, 1'b0, 0);
         end else if (r < 84) begin
            send_packet(mode, sec, $urandom_range(hdr + unit, 524288), 1'b0,
                        $urandom_range(1, 6));
         end else if (r < 92) begin
            repeat ($urandom_range(1, 4))
               send_byte(make_item(8'($urandom_range(0, 255)), 1'b0,
                                   20'($urandom_range(0, 524288)),
                                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))),
                         1'b0, '0);
         end else if (r < 98) begin
            send_packet(mode, sec, hdr + unit + $urandom_range(0, 3),
                        1'($urandom_range(0, 1)), 0);
         end else begin
            send_packet(mode, sec, hdr + $urandom_range(100, 300),
                        1'($urandom_range(0, 1)), 0);
         end
         if (!mid_pressure_done && byte_count > TARGET_BYTES / 2) begin
            mid_pressure_done = 1'b1;
            apply_backpressure();
         end
         if ($urandom_range(0, 19) == 0)
            drain_results();
      end

      drain_results();
      repeat (16) @(posedge clock);
      $display("Covered %0d body bytes in %0d packets under sender gaps and receiver stalls.",
               byte_count, packet_count);
      $display("Status seen: %0d match, %0d mismatch, %0d not present, %0d length error.",
               status_seen[STATUS_MATCH], status_seen[STATUS_MISMATCH],
               status_seen[STATUS_NOT_PRESENT], status_seen[STATUS_LENGTH_ERROR]);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
